// ===== rtl/spmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmc_pkg
// Types, constants and helpers shared by the pump mode controller.
// ----------------------------------------------------------------------------
package spmc_pkg;

  typedef enum logic [2:0] {
    M_RESTART   = 3'd0,
    M_IDLE      = 3'd1,
    M_PAUSED    = 3'd2,
    M_AUTO      = 3'd3,
    M_MANUAL    = 3'd4,
    M_FILL      = 3'd5,
    M_EMERGENCY = 3'd6
  } mode_t;

  localparam logic [1:0] C_EMPTY  = 2'd0;
  localparam logic [1:0] C_PARTLY = 2'd1;
  localparam logic [1:0] C_FULL   = 2'd2;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_ROT  = 2'd2;
  localparam logic [1:0] REG_INIT = 2'd3;

  localparam int CFG_W = 10;
  localparam logic [9:0] MAX_RPM = 10'd14;
  localparam logic [12:0] SPEED_STEP = 13'd4529;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EXEC,
    S_OUT
  } ctl_state_t;

  typedef struct packed {
    logic div_start;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic emergency_pressed;
    logic full_hit;
    logic empty_hit;
    logic inc_press;
    logic dec_press;
    logic auto_press;
    logic manual_feed_press;
    logic manual_feed_held;
    logic fill_press;
    logic fill_held;
    logic second_tick;
  } in_word_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] content;
    logic       motor_on;
    logic       motor_reverse;
    logic [7:0] motor_duty;
    logic [1:0] beep;
    logic [2:0] left_hours;
    logic [5:0] left_minutes;
    logic [5:0] left_seconds;
    logic [7:0] feed_minutes;
    logic       persist_pulse;
    logic       auto_led;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/spmc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmc_in_if / spmc_out_if
// Valid/ready channels for tick words and result words.
// ----------------------------------------------------------------------------
interface spmc_in_if;
  logic                valid;
  logic                ready;
  spmc_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spmc_out_if;
  logic                valid;
  logic                ready;
  spmc_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/syringe_pump_mode_controller.sv =====
`default_nettype none
// Sequence: a tick word is accepted, the 10-step serial divider forms rotations
// per minute of feed time, the word is executed and the result word is held
// valid until taken; a new word is accepted only after the result is taken.
// Reset: synchronous active-low rst_n restores modes and state/config registers.
// ----------------------------------------------------------------------------
// syringe_pump_mode_controller
// Top level: sequencer plus mode/drive datapath.
// ----------------------------------------------------------------------------
module syringe_pump_mode_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata,
  spmc_in_if.sink          in_ch,
  spmc_out_if.source       out_ch
);
  spmc_pkg::cmd_t cmd;
  spmc_pkg::sts_t sts;

  spmc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  spmc_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_data(in_ch.data), .cmd, .sts, .res(out_ch.data)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_ch.valid) else $error("result not presented after execute");
  a_auto_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.auto_led == (out_ch.data.mode == spmc_pkg::M_AUTO)))
    else $error("auto led mismatch");
`endif
endmodule
`default_nettype wire

// ===== rtl/spmc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmc_ctrl
// Sequencer: accept a word, run the speed divider, execute, present result.
// ----------------------------------------------------------------------------
module spmc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output spmc_pkg::cmd_t       cmd,
  input  wire spmc_pkg::sts_t  sts
);
  spmc_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= spmc_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spmc_pkg::S_IDLE: if (in_valid) state_nxt = spmc_pkg::S_DIV;
      spmc_pkg::S_DIV:  if (sts.div_done) state_nxt = spmc_pkg::S_EXEC;
      spmc_pkg::S_EXEC: state_nxt = spmc_pkg::S_OUT;
      spmc_pkg::S_OUT:  if (out_ready) state_nxt = spmc_pkg::S_IDLE;
      default:          state_nxt = spmc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state_r)
      spmc_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.div_start = in_valid;
      end
      spmc_pkg::S_DIV:  ;
      spmc_pkg::S_EXEC: cmd.exec = 1'b1;
      spmc_pkg::S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/spmc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmc_datapath
// Mode machine state, feed time, countdown, motor drive and speed divider.
// ----------------------------------------------------------------------------
module spmc_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [9:0]           cfg_wdata,
  input  wire spmc_pkg::in_word_t   in_data,
  input  wire spmc_pkg::cmd_t       cmd,
  output spmc_pkg::sts_t            sts,
  output spmc_pkg::out_word_t       res
);
  logic [7:0] min_r, max_r, init_r;
  logic [9:0] rot_r;
  spmc_pkg::mode_t mode_r, saved_r;
  logic [7:0] feed_r, stored_r;
  logic       sdone_r;
  logic [2:0] hrs_r;
  logic [5:0] mins_r, secs_r;
  logic       en_r, rev_r;
  logic [7:0] duty_r;
  spmc_pkg::in_word_t in_r;
  spmc_pkg::out_word_t res_r;

  // restoring divider: rot / feed, one quotient bit a cycle
  logic [9:0] quo_r;
  logic [7:0] rem_r;
  logic [3:0] cnt_r;
  logic       busy_r;
  logic [8:0] trial;
  assign trial = {rem_r, quo_r[9]} - {1'b0, feed_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd10;
    end else if (busy_r) begin
      if (cnt_r == 4'd1) busy_r <= 1'b0;
      cnt_r <= cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r  <= rot_r;
      rem_r  <= '0;
      in_r   <= in_data;
    end else if (busy_r) begin
      if (!trial[8] || rem_r[7]) begin
        rem_r <= trial[7:0];
        quo_r <= {quo_r[8:0], 1'b1};
      end else begin
        rem_r <= {rem_r[6:0], quo_r[9]};
        quo_r <= {quo_r[8:0], 1'b0};
      end
    end
  end
  assign sts.div_done = busy_r && (cnt_r == 4'd1);

  // clamp and scale the speed
  logic [9:0]  rpm;
  logic [16:0] scaled;
  logic [7:0]  speed;
  assign rpm    = (quo_r > spmc_pkg::MAX_RPM) ? spmc_pkg::MAX_RPM : quo_r;
  assign scaled = rpm[3:0] * spmc_pkg::SPEED_STEP;
  assign speed  = (feed_r == 8'd0) ? 8'd255 : scaled[15:8];

  // tick execution
  spmc_pkg::mode_t m_n, sv_n;
  logic [7:0] f_n, st_n, duty_n;
  logic       sd_n, en_n, rev_n, persist;
  logic [2:0] h_n;
  logic [5:0] mi_n, s_n;
  logic [1:0] content, beep;
  logic [8:0] fv;

  always_comb begin
    m_n = mode_r; sv_n = saved_r; f_n = feed_r; st_n = stored_r; sd_n = sdone_r;
    h_n = hrs_r; mi_n = mins_r; s_n = secs_r;
    en_n = en_r; rev_n = rev_r; duty_n = duty_r;
    persist = 1'b0; beep = 2'b00; fv = '0;
    // limits
    if (in_r.empty_hit) begin
      if (mode_r != spmc_pkg::M_IDLE) beep[0] = 1'b1;
      content = spmc_pkg::C_EMPTY;
      if (rev_n == spmc_pkg::DIR_REV) begin duty_n = '0; en_n = 1'b0; end
    end else if (in_r.full_hit) begin
      if (mode_r != spmc_pkg::M_IDLE) beep[0] = 1'b1;
      content = spmc_pkg::C_FULL;
      if (rev_n == spmc_pkg::DIR_FWD) begin duty_n = '0; en_n = 1'b0; end
    end else begin
      content = spmc_pkg::C_PARTLY;
    end
    // emergency entry and release
    if (in_r.emergency_pressed) begin
      if (mode_r != spmc_pkg::M_EMERGENCY) begin
        sv_n = mode_r; m_n = spmc_pkg::M_EMERGENCY; duty_n = '0; en_n = 1'b0;
      end
    end else if (mode_r == spmc_pkg::M_EMERGENCY) begin
      m_n = saved_r;
    end
    case (m_n)
      spmc_pkg::M_EMERGENCY: ;
      spmc_pkg::M_IDLE: begin
        if (in_r.inc_press) begin
          fv = {1'b0, f_n} + 9'd1;
          if (fv > {1'b0, max_r}) f_n = min_r;
          else if (fv < {1'b0, min_r}) f_n = max_r;
          else f_n = fv[7:0];
        end
        // a step below zero always lies under the minimum: load the maximum
        if (in_r.dec_press) begin
          if (f_n == 8'd0) f_n = max_r;
          else begin
            fv = {1'b0, f_n} - 9'd1;
            if (fv > {1'b0, max_r}) f_n = min_r;
            else if (fv < {1'b0, min_r}) f_n = max_r;
            else f_n = fv[7:0];
          end
        end
        if (content == spmc_pkg::C_FULL) begin
          if (in_r.auto_press) m_n = spmc_pkg::M_AUTO;
          if (in_r.manual_feed_press) m_n = spmc_pkg::M_MANUAL;
        end else if (in_r.fill_press) m_n = spmc_pkg::M_FILL;
        h_n = 3'd0;
        mi_n = f_n[5:0];
        if (f_n >= 8'd240) begin h_n = 3'd4; mi_n = 6'(f_n - 8'd240); end
        else if (f_n >= 8'd180) begin h_n = 3'd3; mi_n = 6'(f_n - 8'd180); end
        else if (f_n >= 8'd120) begin h_n = 3'd2; mi_n = 6'(f_n - 8'd120); end
        else if (f_n >= 8'd60) begin h_n = 3'd1; mi_n = 6'(f_n - 8'd60); end
        s_n = '0;
      end
      spmc_pkg::M_PAUSED: begin
        if (in_r.auto_press) m_n = spmc_pkg::M_AUTO;
        if (in_r.manual_feed_press) m_n = spmc_pkg::M_MANUAL;
      end
      spmc_pkg::M_AUTO, spmc_pkg::M_MANUAL: begin
        if (!sdone_r && feed_r != stored_r) begin
          persist = 1'b1; st_n = feed_r; sd_n = 1'b1;
        end
        if (m_n == spmc_pkg::M_MANUAL && !in_r.manual_feed_held) begin
          m_n = spmc_pkg::M_PAUSED;
          if (rev_n == spmc_pkg::DIR_REV) begin duty_n = '0; en_n = 1'b0; end
        end else if ((hrs_r != 3'd0 || mins_r != 6'd0 || secs_r != 6'd0)
                     && content != spmc_pkg::C_EMPTY) begin
          if (speed != duty_n || rev_n != spmc_pkg::DIR_REV) begin
            duty_n = speed; rev_n = spmc_pkg::DIR_REV; en_n = 1'b1;
          end
          if (in_r.second_tick) begin
            if (secs_r != 6'd0) s_n = secs_r - 6'd1;
            else if (mins_r != 6'd0) begin mi_n = mins_r - 6'd1; s_n = 6'd59; end
            else if (hrs_r != 3'd0) begin
              h_n = hrs_r - 3'd1; mi_n = 6'd59; s_n = 6'd59;
            end
          end
        end else m_n = spmc_pkg::M_RESTART;
      end
      spmc_pkg::M_FILL: begin
        if (in_r.fill_held && content != spmc_pkg::C_FULL) begin
          if (duty_n != 8'd255 || rev_n != spmc_pkg::DIR_FWD) begin
            duty_n = 8'd255; rev_n = spmc_pkg::DIR_FWD; en_n = 1'b1;
          end
        end else begin
          m_n = spmc_pkg::M_IDLE;
          if (rev_n == spmc_pkg::DIR_FWD) begin duty_n = '0; en_n = 1'b0; end
        end
      end
      default: begin
        beep[1] = 1'b1; m_n = spmc_pkg::M_IDLE;
      end
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 8'd1; max_r <= 8'd255; rot_r <= 10'd29; init_r <= 8'd0;
      mode_r <= spmc_pkg::M_RESTART; saved_r <= spmc_pkg::M_RESTART;
      feed_r <= 8'd0; stored_r <= 8'd0; sdone_r <= 1'b0;
      hrs_r <= '0; mins_r <= '0; secs_r <= '0;
      en_r <= 1'b0; rev_r <= spmc_pkg::DIR_FWD; duty_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spmc_pkg::REG_MIN: min_r <= cfg_wdata[7:0];
        spmc_pkg::REG_MAX: max_r <= cfg_wdata[7:0];
        spmc_pkg::REG_ROT: rot_r <= cfg_wdata;
        spmc_pkg::REG_INIT: begin
          init_r <= cfg_wdata[7:0]; feed_r <= cfg_wdata[7:0];
          stored_r <= cfg_wdata[7:0]; sdone_r <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.exec) begin
      mode_r <= m_n; saved_r <= sv_n; feed_r <= f_n; stored_r <= st_n;
      sdone_r <= sd_n; hrs_r <= h_n; mins_r <= mi_n; secs_r <= s_n;
      en_r <= en_n; rev_r <= rev_n; duty_r <= duty_n;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r.mode          <= m_n;
      res_r.content       <= content;
      res_r.motor_on      <= en_n;
      res_r.motor_reverse <= rev_n;
      res_r.motor_duty    <= duty_n;
      res_r.beep          <= beep;
      res_r.left_hours    <= h_n;
      res_r.left_minutes  <= mi_n;
      res_r.left_seconds  <= s_n;
      res_r.feed_minutes  <= f_n;
      res_r.persist_pulse <= persist;
      res_r.auto_led      <= (m_n == spmc_pkg::M_AUTO);
    end
  end
  assign res = res_r;
  logic unused_init;
  assign unused_init = ^init_r;
endmodule
`default_nettype wire
